// ===== design/resident_page_run_extractor_unit_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef RESIDENT_PAGE_RUN_EXTRACTOR_UNIT_MACROS_SVH
`define RESIDENT_PAGE_RUN_EXTRACTOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPRE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rpre_pkg.sv =====
`default_nettype none
package rpre_pkg;

    localparam int PAGE_SHIFT = 12;
    localparam int IDX_W = 52;
    localparam logic [63:0] PAGE_BYTES = 64'd1 << PAGE_SHIFT;

    localparam int BIT_PRESENT = 63;
    localparam int BIT_SWAPPED = 62;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] REG_REGION_BASE = 2'd0;
    localparam logic [1:0] REG_REGION_SIZE = 2'd1;
    localparam logic [1:0] REG_MAX_RUNS = 2'd2;

    localparam logic REQ_ENTRY = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [63:0] entry;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] run_addr;
        logic [63:0] run_len;
        logic [63:0] resident_bytes;
        logic [63:0] swapped_bytes;
        logic [15:0] run_count;
        logic        more_runs;
        logic        status;
        logic        last;
    } out_item_t;

    // Results produced by one item, in order; count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } push_t;

endpackage
`default_nettype wire

// ===== design/rpre_core.sv =====
`default_nettype none
module rpre_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_data,
    input  wire logic              fire,
    input  wire rpre_pkg::in_item_t item,
    output rpre_pkg::push_t        push
);

    logic [63:0] region_base_reg;
    logic [63:0] region_size_reg;
    logic [15:0] max_runs_reg;

    logic [rpre_pkg::IDX_W-1:0] page_index_reg, page_index_next;
    logic [rpre_pkg::IDX_W-1:0] run_pages_reg, run_pages_next;
    logic [63:0] run_start_reg, run_start_next;
    logic [63:0] resident_total_reg, resident_total_next;
    logic [63:0] swapped_total_reg, swapped_total_next;
    logic [15:0] runs_emitted_reg, runs_emitted_next;
    logic        overflow_flag_reg, overflow_flag_next;

    logic        region_ok;
    logic [63:0] page_total;
    logic        in_range;
    logic        closing;
    logic        room;
    logic        sent;
    logic [63:0] rec_len;
    logic [63:0] run_end;
    logic [63:0] region_end;
    logic [63:0] tail_len;
    logic [63:0] new_start;
    rpre_pkg::out_item_t record_item;
    rpre_pkg::out_item_t tail_item;
    rpre_pkg::out_item_t summary_item;
    rpre_pkg::out_item_t bad_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
            region_size_reg <= '0;
            max_runs_reg    <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rpre_pkg::REG_REGION_BASE)
            begin
                region_base_reg <= cfg_data;
            end
            else if (cfg_index == rpre_pkg::REG_REGION_SIZE)
            begin
                region_size_reg <= cfg_data;
            end
            else if (cfg_index == rpre_pkg::REG_MAX_RUNS)
            begin
                max_runs_reg <= cfg_data[15:0];
            end
        end
    end

    assign region_ok = (region_base_reg[rpre_pkg::PAGE_SHIFT-1:0] == '0)
                       && (region_size_reg != '0);
    assign page_total = (region_size_reg >> rpre_pkg::PAGE_SHIFT)
                        + 64'(|region_size_reg[rpre_pkg::PAGE_SHIFT-1:0]);
    assign in_range   = 64'(page_index_reg) < page_total;
    assign closing    = run_pages_reg != '0;
    assign room       = runs_emitted_reg < max_runs_reg;
    assign sent       = closing && room;
    assign rec_len    = 64'(run_pages_reg) << rpre_pkg::PAGE_SHIFT;
    assign run_end    = run_start_reg + rec_len;
    assign region_end = region_base_reg + region_size_reg;
    assign tail_len   = (run_end > region_end) ? (region_end - run_start_reg) : rec_len;
    assign new_start  = region_base_reg + (64'(page_index_reg) << rpre_pkg::PAGE_SHIFT);

    always_comb
    begin
        record_item          = '0;
        record_item.kind     = rpre_pkg::KIND_RECORD;
        record_item.run_addr = run_start_reg;
        record_item.run_len  = rec_len;

        tail_item         = record_item;
        tail_item.run_len = tail_len;

        summary_item                = '0;
        summary_item.kind           = rpre_pkg::KIND_SUMMARY;
        summary_item.resident_bytes = resident_total_reg;
        summary_item.swapped_bytes  = swapped_total_reg;
        summary_item.run_count      = runs_emitted_reg + 16'(sent);
        summary_item.more_runs      = overflow_flag_reg | (closing && !room);
        summary_item.status         = rpre_pkg::STATUS_OK;
        summary_item.last           = 1'b1;

        bad_item        = '0;
        bad_item.kind   = rpre_pkg::KIND_SUMMARY;
        bad_item.status = rpre_pkg::STATUS_BAD;
        bad_item.last   = 1'b1;
    end

    always_comb
    begin
        page_index_next     = page_index_reg;
        run_pages_next      = run_pages_reg;
        run_start_next      = run_start_reg;
        resident_total_next = resident_total_reg;
        swapped_total_next  = swapped_total_reg;
        runs_emitted_next   = runs_emitted_reg;
        overflow_flag_next  = overflow_flag_reg;
        push                = '0;

        if (fire)
        begin
            if (item.req_type == rpre_pkg::REQ_ENTRY)
            begin
                if (region_ok && in_range)
                begin
                    if (item.entry[rpre_pkg::BIT_PRESENT])
                    begin
                        resident_total_next = resident_total_reg + rpre_pkg::PAGE_BYTES;
                        if (!closing)
                        begin
                            run_start_next = new_start;
                        end
                        run_pages_next = run_pages_reg + rpre_pkg::IDX_W'(1);
                    end
                    else
                    begin
                        if (item.entry[rpre_pkg::BIT_SWAPPED])
                        begin
                            swapped_total_next = swapped_total_reg + rpre_pkg::PAGE_BYTES;
                        end
                        if (closing)
                        begin
                            if (room)
                            begin
                                runs_emitted_next = runs_emitted_reg + 16'd1;
                                push.count        = 2'd1;
                                push.first        = record_item;
                            end
                            else
                            begin
                                overflow_flag_next = 1'b1;
                            end
                            run_pages_next = '0;
                        end
                    end
                    page_index_next = page_index_reg + rpre_pkg::IDX_W'(1);
                end
            end
            else
            begin
                if (!region_ok)
                begin
                    push.count = 2'd1;
                    push.first = bad_item;
                end
                else if (sent)
                begin
                    push.count  = 2'd2;
                    push.first  = tail_item;
                    push.second = summary_item;
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = summary_item;
                end
                page_index_next     = '0;
                run_pages_next      = '0;
                run_start_next      = '0;
                resident_total_next = '0;
                swapped_total_next  = '0;
                runs_emitted_next   = '0;
                overflow_flag_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_index_reg     <= '0;
            run_pages_reg      <= '0;
            run_start_reg      <= '0;
            resident_total_reg <= '0;
            swapped_total_reg  <= '0;
            runs_emitted_reg   <= '0;
            overflow_flag_reg  <= 1'b0;
        end
        else
        begin
            page_index_reg     <= page_index_next;
            run_pages_reg      <= run_pages_next;
            run_start_reg      <= run_start_next;
            resident_total_reg <= resident_total_next;
            swapped_total_reg  <= swapped_total_next;
            runs_emitted_reg   <= runs_emitted_next;
            overflow_flag_reg  <= overflow_flag_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/rpre_out_fifo.sv =====
`default_nettype none
module rpre_out_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rpre_pkg::push_t    push,
    output logic                    space_ok,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rpre_pkg::out_item_t     out_item
);

    rpre_pkg::out_item_t mem [rpre_pkg::FIFO_DEPTH];

    logic [rpre_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [rpre_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [rpre_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       pop;

    assign out_valid = count_reg != '0;
    assign out_item  = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign space_ok  = count_reg <= rpre_pkg::CNT_W'(rpre_pkg::FIFO_DEPTH - 2);

    assign wr_ptr_next = wr_ptr_reg + rpre_pkg::PTR_W'(push.count);
    assign rd_ptr_next = rd_ptr_reg + rpre_pkg::PTR_W'(pop);
    assign count_next  = count_reg + rpre_pkg::CNT_W'(push.count)
                         - rpre_pkg::CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + rpre_pkg::PTR_W'(1)] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/resident_page_run_extractor_unit.sv =====
// Scans the page-map entries of one region and emits resident runs plus a summary.
// The block accepts one item per cycle while the result queue has room: an item
// enters an input register, is processed against the run state once the queue
// has room, and its results are written into a four-entry result queue, which
// registers them before output. A finish item yields up to two results (tail run
// and summary); the queue drains one result per cycle while the consumer is ready,
// so a steady item stream is limited only by how fast the consumer takes results.
`default_nettype none
module resident_page_run_extractor_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [63:0]         cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire rpre_pkg::in_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output rpre_pkg::out_item_t      out_item
);

    logic               hold_valid_reg, hold_valid_next;
    rpre_pkg::in_item_t hold_item_reg;
    logic               space_ok;
    logic               fire;
    logic               in_accept;
    rpre_pkg::push_t    push;

    assign fire      = hold_valid_reg && space_ok;
    assign in_ready  = !hold_valid_reg || fire;
    assign in_accept = in_valid && in_ready;

    assign hold_valid_next = in_accept || (hold_valid_reg && !fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            hold_item_reg <= in_item;
        end
    end

    rpre_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (hold_item_reg),
        .push      (push)
    );

    rpre_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

// ===== design/rpre_checker.sv =====
`default_nettype none
`include "resident_page_run_extractor_unit_macros.svh"
module rpre_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire rpre_pkg::out_item_t out_item
);

    `RPRE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result item dropped while stalled")
    `RPRE_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_item), "result item changed while stalled")
    `RPRE_ASSERT_SAME(a_summary_last, out_valid && (out_item.kind == rpre_pkg::KIND_SUMMARY), out_item.last, "summary item without last")
    `RPRE_ASSERT_SAME(a_record_clean, out_valid && (out_item.kind == rpre_pkg::KIND_RECORD), !out_item.last && (out_item.status == rpre_pkg::STATUS_OK) && (out_item.resident_bytes == '0), "run record carries summary fields")

endmodule

bind resident_page_run_extractor_unit rpre_checker u_rpre_checker (.*);
`default_nettype wire

// ===== test/tb_resident_page_run_extractor_unit.sv =====
`default_nettype none
module tb_resident_page_run_extractor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_ITEMS = 800;

    logic                logic_unused_guard;
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = rpre_pkg::REG_REGION_BASE;
    logic [63:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    rpre_pkg::in_item_t  in_item = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    rpre_pkg::out_item_t out_item;

    assign logic_unused_guard = 1'b0;

    resident_page_run_extractor_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Shadow copy of the registers and the scan state.
    logic [63:0] reg_base = '0;
    logic [63:0] reg_size = '0;
    logic [15:0] reg_max_runs = 16'hFFFF;
    logic [51:0] scan_page = '0;
    logic [51:0] open_pages = '0;
    logic [63:0] open_start = '0;
    logic [63:0] resident_sum = '0;
    logic [63:0] swapped_sum = '0;
    logic [15:0] runs_sent = '0;
    logic        runs_dropped = 1'b0;

    rpre_pkg::out_item_t pending_results[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned stall_left = 0;
    int unsigned random_items = 0;
    bit          steady_flow = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("resident_page_run_extractor_unit regression: fail");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // The receiver stalls at random unless steady flow is set; a requested hold keeps it stalled for a long stretch.
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served <= hold_served + 1;
            stall_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (steady_flow || $urandom_range(0, 99) < 70)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            stall_left <= pick_gap();
            out_ready <= 1'b0;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    task automatic check_result(input rpre_pkg::out_item_t got);
        rpre_pkg::out_item_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("unexpected result, kind", 64'(got.kind), '0);
            return;
        end
        want = pending_results.pop_front();
        check_field("kind", 64'(got.kind), 64'(want.kind));
        check_field("run_addr", got.run_addr, want.run_addr);
        check_field("run_len", got.run_len, want.run_len);
        check_field("resident_bytes", got.resident_bytes, want.resident_bytes);
        check_field("swapped_bytes", got.swapped_bytes, want.swapped_bytes);
        check_field("run_count", 64'(got.run_count), 64'(want.run_count));
        check_field("more_runs", 64'(got.more_runs), 64'(want.more_runs));
        check_field("status", 64'(got.status), 64'(want.status));
        check_field("last", 64'(got.last), 64'(want.last));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result(out_item);
    end

    function automatic logic region_valid();
        return ((reg_base & (rpre_pkg::PAGE_BYTES - 64'd1)) == 64'd0) && (reg_size != 64'd0);
    endfunction

    function automatic logic [63:0] region_page_count();
        logic [63:0] pages;
        pages = reg_size >> rpre_pkg::PAGE_SHIFT;
        if ((reg_size & (rpre_pkg::PAGE_BYTES - 64'd1)) != 64'd0)
            pages = pages + 64'd1;
        return pages;
    endfunction

    task automatic clear_scan();
        scan_page = '0;
        open_pages = '0;
        open_start = '0;
        resident_sum = '0;
        swapped_sum = '0;
        runs_sent = '0;
        runs_dropped = 1'b0;
    endtask

    task automatic close_open_run(output logic sent, output logic [63:0] addr,
                                  output logic [63:0] len);
        sent = 1'b0;
        addr = '0;
        len = '0;
        if (open_pages != '0)
        begin
            if (runs_sent < reg_max_runs)
            begin
                addr = open_start;
                len = {12'd0, open_pages} << rpre_pkg::PAGE_SHIFT;
                runs_sent = runs_sent + 16'd1;
                sent = 1'b1;
            end
            else
            begin
                runs_dropped = 1'b1;
            end
            open_pages = '0;
        end
    endtask

    task automatic track_page_item(input rpre_pkg::in_item_t item);
        rpre_pkg::out_item_t res;
        logic        sent;
        logic [63:0] addr;
        logic [63:0] len;
        logic [63:0] region_end;
        if (item.req_type == rpre_pkg::REQ_ENTRY)
        begin
            if (!region_valid() || {12'd0, scan_page} >= region_page_count())
                return;
            if (item.entry[rpre_pkg::BIT_PRESENT])
            begin
                resident_sum = resident_sum + rpre_pkg::PAGE_BYTES;
                if (open_pages == '0)
                    open_start = reg_base + ({12'd0, scan_page} << rpre_pkg::PAGE_SHIFT);
                open_pages = open_pages + 52'd1;
            end
            else
            begin
                if (item.entry[rpre_pkg::BIT_SWAPPED])
                    swapped_sum = swapped_sum + rpre_pkg::PAGE_BYTES;
                close_open_run(sent, addr, len);
                if (sent)
                begin
                    res = '0;
                    res.kind = rpre_pkg::KIND_RECORD;
                    res.run_addr = addr;
                    res.run_len = len;
                    pending_results.push_back(res);
                end
            end
            scan_page = scan_page + 52'd1;
            return;
        end
        if (!region_valid())
        begin
            res = '0;
            res.kind = rpre_pkg::KIND_SUMMARY;
            res.status = rpre_pkg::STATUS_BAD;
            res.last = 1'b1;
            pending_results.push_back(res);
            clear_scan();
            return;
        end
        close_open_run(sent, addr, len);
        if (sent)
        begin
            region_end = reg_base + reg_size;
            if (addr + len > region_end)
                len = region_end - addr;
            res = '0;
            res.kind = rpre_pkg::KIND_RECORD;
            res.run_addr = addr;
            res.run_len = len;
            pending_results.push_back(res);
        end
        res = '0;
        res.kind = rpre_pkg::KIND_SUMMARY;
        res.resident_bytes = resident_sum;
        res.swapped_bytes = swapped_sum;
        res.run_count = runs_sent;
        res.more_runs = runs_dropped;
        res.status = rpre_pkg::STATUS_OK;
        res.last = 1'b1;
        pending_results.push_back(res);
        clear_scan();
    endtask

    // The valid line is lowered only when a gap follows, so it is never dropped and
    // raised in the same step.
    task automatic send_item(input rpre_pkg::in_item_t item);
        int unsigned gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_page_item(item);
    endtask

    task automatic send_entry(input logic [63:0] word);
        rpre_pkg::in_item_t item;
        item.req_type = rpre_pkg::REQ_ENTRY;
        item.entry = word;
        send_item(item);
    endtask

    task automatic send_finish();
        rpre_pkg::in_item_t item;
        item.req_type = rpre_pkg::REQ_FINISH;
        item.entry = {$urandom, $urandom};
        send_item(item);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [63:0] base, input logic [63:0] size,
                             input logic [15:0] max_recs);
        cfg_we <= 1'b1;
        cfg_index <= rpre_pkg::REG_REGION_BASE;
        cfg_data <= base;
        @(posedge clk);
        reg_base = base;
        cfg_index <= rpre_pkg::REG_REGION_SIZE;
        cfg_data <= size;
        @(posedge clk);
        reg_size = size;
        cfg_index <= rpre_pkg::REG_MAX_RUNS;
        cfg_data <= {48'd0, max_recs};
        @(posedge clk);
        reg_max_runs = max_recs;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] random_entry(input logic present);
        logic [63:0] word;
        word = {$urandom, $urandom};
        word[rpre_pkg::BIT_PRESENT] = present;
        return word;
    endfunction

    task automatic test_reset_defaults();
        send_entry(64'h8000_0000_0000_0000);
        send_finish();
        wait_idle();
    endtask

    task automatic test_basic_scan();
        configure(64'h0000_0000_0001_0000, 64'h0000_0000_0000_6000, 16'hFFFF);
        send_entry(64'hFFFF_FFFF_FFFF_FFFF);
        send_entry(64'h8000_0000_0000_0000);
        send_entry(64'h4000_0000_0000_0000);
        send_entry(64'h0000_0000_0000_0000);
        send_entry(64'h7FFF_FFFF_FFFF_FFFF);
        send_entry(64'h8000_0000_0000_0000);
        send_finish();
        wait_idle();
    endtask

    task automatic test_unaligned_base();
        configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_entry(64'hC000_0000_0000_0000);
        send_finish();
        wait_idle();
    endtask

    task automatic test_tail_clamp();
        configure(64'h0000_0000_0000_0000, 64'h0000_0000_0000_1800, 16'hFFFF);
        send_entry(64'h8000_0000_0000_0000);
        send_entry(64'h8000_0000_0000_0000);
        send_entry(64'h4000_0000_0000_0000);
        send_finish();
        wait_idle();
        configure(64'hFFFF_FFFF_FFFF_E000, 64'h0000_0000_0000_1800, 16'hFFFF);
        send_entry(64'h8000_0000_0000_0000);
        send_entry(64'hC000_0000_0000_0000);
        send_finish();
        wait_idle();
    endtask

    task automatic test_run_limit();
        configure(64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1);
        send_entry(64'h8000_0000_0000_0000);
        send_entry(64'h0000_0000_0000_0000);
        send_entry(64'h8000_0000_0000_0000);
        send_entry(64'h4000_0000_0000_0000);
        send_entry(64'h8000_0000_0000_0000);
        send_finish();
        wait_idle();
        configure(64'h0000_0000_0000_0000, 64'h0000_0000_0000_4000, 16'd0);
        send_entry(64'h8000_0000_0000_0000);
        send_entry(64'h0000_0000_0000_0000);
        send_entry(64'h8000_0000_0000_0000);
        send_finish();
        wait_idle();
    endtask

    task automatic test_backpressure();
        int unsigned n;
        configure(64'h0000_0000_0020_0000, 64'h0000_0000_0004_0000, 16'hFFFF);
        steady_flow = 1'b1;
        hold_requests++;
        for (n = 0; n < 64; n++)
            send_entry(random_entry(n[0] == 1'b0));
        send_finish();
        wait_idle();
        steady_flow = 1'b0;
    endtask

    task automatic randomize_region();
        logic [63:0] base;
        logic [63:0] size;
        logic [15:0] max_recs;
        int unsigned sel;
        base = {$urandom, $urandom};
        sel = $urandom_range(0, 19);
        if (sel == 0)
            base = '0;
        else if (sel == 1)
            base = 64'hFFFF_FFFF_FFFF_F000;
        else if (sel == 2)
            base[$urandom_range(0, rpre_pkg::PAGE_SHIFT - 1)] = 1'b1;
        else
            base = base & ~(rpre_pkg::PAGE_BYTES - 64'd1);
        sel = $urandom_range(0, 24);
        if (sel == 0)
            size = '0;
        else if (sel == 1)
            size = '1;
        else
            size = (64'($urandom_range(1, 40)) << rpre_pkg::PAGE_SHIFT)
                   - 64'($urandom_range(0, 4095));
        sel = $urandom_range(0, 19);
        if (sel == 0)
            max_recs = '0;
        else if (sel == 1)
            max_recs = 16'hFFFF;
        else if (sel == 2)
            max_recs = 16'($urandom);
        else
            max_recs = 16'($urandom_range(1, 8));
        configure(base, size, max_recs);
    endtask

    task automatic run_random_scan();
        logic [63:0] page_total;
        int unsigned pages;
        int unsigned n;
        int unsigned sel;
        logic        present;
        if ($urandom_range(0, 99) < 70)
        begin
            wait_idle();
            randomize_region();
        end
        steady_flow = ($urandom_range(0, 9) == 0);
        page_total = region_page_count();
        if (!region_valid() || page_total > 64'd64)
            pages = $urandom_range(0, 30);
        else
            pages = int'(page_total);
        sel = $urandom_range(0, 99);
        if (sel < 15)
            pages = $urandom_range(0, pages);
        else if (sel < 30)
            pages = pages + $urandom_range(1, 4);
        present = $urandom_range(0, 1);
        for (n = 0; n < pages; n++)
        begin
            if ($urandom_range(0, 99) < 35)
                present = !present;
            send_entry(random_entry(present));
        end
        send_finish();
        random_items += pages + 1;
    endtask

    task automatic test_random_scans();
        while (random_items < RANDOM_ITEMS)
            run_random_scan();
        wait_idle();
        steady_flow = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_basic_scan();
        test_unaligned_base();
        test_tail_clamp();
        test_run_limit();
        test_backpressure();
        test_random_scans();
        wait_idle();
        if (mismatch_count == 0 && pending_results.size() == 0 && !logic_unused_guard)
            $display("resident_page_run_extractor_unit regression: pass");
        else
            $display("resident_page_run_extractor_unit regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+design
design/rpre_pkg.sv
design/rpre_core.sv
design/rpre_out_fifo.sv
design/resident_page_run_extractor_unit.sv
design/rpre_checker.sv
test/tb_resident_page_run_extractor_unit.sv
